>>> sv/seeded_four_lane_block_hash_assert.svh
// Assertion macros shared by the block hash RTL
`ifndef SEEDED_FOUR_LANE_BLOCK_HASH_ASSERT_SVH
`define SEEDED_FOUR_LANE_BLOCK_HASH_ASSERT_SVH
// Same-cycle implication, disabled while reset is active
`define SFLBH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is active
`define SFLBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/sflbh_pkg.sv
// Types, constants and helper functions of the block hash
`timescale 1ns / 1ps
`default_nettype none
package sflbh_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned NLANES      = 4;
  localparam int unsigned LANE_BYTES  = 8;
  localparam int unsigned BLOCK_BYTES = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam word_t MUL_B  = 64'h94d049bb133111eb;
  localparam word_t GOLD   = 64'h9e3779b97f4a7c15;
  localparam word_t FMX_A  = 64'hff51afd7ed558ccd;
  localparam word_t FMX_B  = 64'hc4ceb9fe1a85ec53;
  localparam word_t WIDE_K = 64'h517cc1b727220a95;

  localparam word_t INIT_CONST [NLANES] = '{
    64'h243f6a8885a308d3, 64'h13198a2e03707344,
    64'ha4093822299f31d0, 64'h082efa98ec4e6c89
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED = 2'd0,
    CFG_WIDE = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LOP_SKIP,
    LOP_TAIL,
    LOP_FULL
  } lane_op_e;

  typedef struct packed {
    lane_op_e   op;
    logic [3:0] nbytes;
    word_t      word;
    word_t      acc;
  } lane_cmd_t;

  typedef struct packed {
    word_t      mul_first;
    word_t      mul_second;
    logic [5:0] rot_full;
    logic [5:0] rot_tail;
  } lane_const_t;

  typedef struct packed {
    word_t [NLANES-1:0] acc;
    word_t              len;
    logic               wide;
  } fin_cmd_t;

  function automatic word_t rotl64(input word_t v, input logic [5:0] n);
    logic [2*WORD_W-1:0] d;
    d = {v, v} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t fold33(input word_t x);
    return x ^ (x >> 33);
  endfunction

  function automatic lane_const_t lane_const(input logic [1:0] idx);
    lane_const_t k;
    case (idx)
      2'd0: k = '{mul_first: MUL_A, mul_second: MUL_B, rot_full: 6'd31, rot_tail: 6'd13};
      2'd1: k = '{mul_first: MUL_B, mul_second: MUL_A, rot_full: 6'd27, rot_tail: 6'd17};
      2'd2: k = '{mul_first: MUL_A, mul_second: MUL_B, rot_full: 6'd33, rot_tail: 6'd23};
      2'd3: k = '{mul_first: MUL_B, mul_second: MUL_A, rot_full: 6'd29, rot_tail: 6'd37};
      default: k = '{mul_first: MUL_A, mul_second: MUL_B, rot_full: 6'd31, rot_tail: 6'd13};
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> sv/sflbh_if.sv
// Handshake channels of the block hash: config writes, input blocks, results
`timescale 1ns / 1ps
`default_nettype none
interface sflbh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sflbh_pkg::CFG_IDX_W-1:0]  index;
  logic [sflbh_pkg::WORD_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface sflbh_in_if;
  logic                          valid;
  logic                          ready;
  logic [sflbh_pkg::WORD_W-1:0]  lane_zero;
  logic [sflbh_pkg::WORD_W-1:0]  lane_one;
  logic [sflbh_pkg::WORD_W-1:0]  lane_two;
  logic [sflbh_pkg::WORD_W-1:0]  lane_three;
  logic [sflbh_pkg::LEN_W-1:0]   valid_bytes;
  logic                          last_block;
  modport source (output valid, output lane_zero, output lane_one, output lane_two,
                  output lane_three, output valid_bytes, output last_block, input ready);
  modport sink (input valid, input lane_zero, input lane_one, input lane_two,
                input lane_three, input valid_bytes, input last_block, output ready);
endinterface

interface sflbh_out_if;
  logic                          valid;
  logic                          ready;
  logic [sflbh_pkg::WORD_W-1:0]  hash_low;
  logic [sflbh_pkg::WORD_W-1:0]  hash_high;
  modport source (output valid, output hash_low, output hash_high, input ready);
  modport sink (input valid, input hash_low, input hash_high, output ready);
endinterface
`default_nettype wire

>>> sv/sflbh_mul.sv
// Two-stage 64x64 multiplier keeping the low 64 bits of the product
`timescale 1ns / 1ps
`default_nettype none
module sflbh_mul (
  input  logic                 clk_i,
  input  sflbh_pkg::word_t     a_i,
  input  sflbh_pkg::word_t     b_i,
  output sflbh_pkg::word_t     p_o
);

  sflbh_pkg::word_t ll;
  sflbh_pkg::word_t lh;
  sflbh_pkg::word_t hl;
  sflbh_pkg::word_t pp_ll_q;
  logic [31:0]      pp_lh_q;
  logic [31:0]      pp_hl_q;
  sflbh_pkg::word_t prod_q;

  assign ll = a_i[31:0] * b_i[31:0];
  assign lh = a_i[31:0] * b_i[63:32];
  assign hl = a_i[63:32] * b_i[31:0];

  // partial products, then their sum; cross terms only reach the upper half
  always_ff @(posedge clk_i) begin
    pp_ll_q <= ll;
    pp_lh_q <= lh[31:0];
    pp_hl_q <= hl[31:0];
    prod_q  <= pp_ll_q + {pp_lh_q + pp_hl_q, 32'b0};
  end

  assign p_o = prod_q;

endmodule
`default_nettype wire

>>> sv/sflbh_lane.sv
// One lane: multiply-rotate-multiply round or masked tail step on one accumulator
`timescale 1ns / 1ps
`default_nettype none
module sflbh_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  sflbh_pkg::lane_cmd_t    cmd_i,
  input  sflbh_pkg::lane_const_t  lane_k_i,
  output logic                    done_o,
  output sflbh_pkg::word_t        res_o
);

  typedef enum logic [2:0] {
    LS_IDLE, LS_M1A, LS_M1B, LS_RND, LS_M2A, LS_M2B, LS_WB, LS_DONE
  } lane_state_e;

  lane_state_e      state_q;
  logic             full_q;
  sflbh_pkg::word_t op_a_q;
  sflbh_pkg::word_t op_b_q;
  sflbh_pkg::word_t acc_q;
  sflbh_pkg::word_t res_q;
  sflbh_pkg::word_t prod;
  sflbh_pkg::word_t mask;

  // keep only the bytes present in this group
  assign mask = cmd_i.nbytes[3] ? '1 :
                (64'd1 << {cmd_i.nbytes[2:0], 3'b000}) - 64'd1;

  sflbh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a_q),
    .b_i   (op_b_q),
    .p_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LS_IDLE;
      full_q  <= 1'b0;
      op_a_q  <= '0;
      op_b_q  <= '0;
      acc_q   <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        LS_IDLE, LS_DONE: begin
          if (start_i) begin
            case (cmd_i.op)
              sflbh_pkg::LOP_FULL: begin
                full_q  <= 1'b1;
                op_a_q  <= cmd_i.word;
                op_b_q  <= lane_k_i.mul_first;
                acc_q   <= cmd_i.acc;
                state_q <= LS_M1A;
              end
              sflbh_pkg::LOP_TAIL: begin
                full_q  <= 1'b0;
                op_a_q  <= cmd_i.acc ^ (cmd_i.word & mask);
                op_b_q  <= sflbh_pkg::MUL_A;
                state_q <= LS_M1A;
              end
              default: begin
                res_q   <= cmd_i.acc;
                state_q <= LS_DONE;
              end
            endcase
          end
        end
        LS_M1A: state_q <= LS_M1B;
        LS_M1B: state_q <= LS_RND;
        LS_RND: begin
          if (full_q) begin
            op_a_q  <= sflbh_pkg::rotl64(acc_q + prod, lane_k_i.rot_full);
            op_b_q  <= lane_k_i.mul_second;
            state_q <= LS_M2A;
          end else begin
            res_q   <= sflbh_pkg::rotl64(prod, lane_k_i.rot_tail);
            state_q <= LS_DONE;
          end
        end
        LS_M2A: state_q <= LS_M2B;
        LS_M2B: state_q <= LS_WB;
        LS_WB: begin
          res_q   <= prod;
          state_q <= LS_DONE;
        end
        default: state_q <= LS_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == LS_DONE);
  assign res_o  = res_q;

endmodule
`default_nettype wire

>>> sv/sflbh_final.sv
// Finalisation: length mixing and avalanche steps over one shared multiplier
`timescale 1ns / 1ps
`default_nettype none
`include "seeded_four_lane_block_hash_assert.svh"
module sflbh_final (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sflbh_pkg::fin_cmd_t  cmd_i,
  input  logic                 ack_i,
  output logic                 done_o,
  output sflbh_pkg::word_t     hash_low_o,
  output sflbh_pkg::word_t     hash_high_o
);

  typedef enum logic [2:0] {F_IDLE, F_ISSUE, F_PP, F_SUM, F_DONE} fin_state_e;
  typedef enum logic [2:0] {
    STEP_PRE_A, STEP_PRE_B, STEP_MIX_A, STEP_MIX_B, STEP_MIX_C, STEP_MIX_D
  } fin_step_e;

  fin_state_e          state_q;
  fin_step_e           step_q;
  sflbh_pkg::fin_cmd_t cmd_q;
  sflbh_pkg::word_t    u_q;
  sflbh_pkg::word_t    w_q;
  sflbh_pkg::word_t    mul_a;
  sflbh_pkg::word_t    mul_b;
  sflbh_pkg::word_t    prod;
  logic                last_step;

  // operand selection per step; the wide result runs two avalanche chains
  always_comb begin
    mul_a = cmd_q.len;
    mul_b = sflbh_pkg::GOLD;
    case (step_q)
      STEP_PRE_A: begin
        mul_a = cmd_q.len;
        mul_b = sflbh_pkg::GOLD;
      end
      STEP_PRE_B: begin
        mul_a = cmd_q.wide ? cmd_q.len : sflbh_pkg::fold33(cmd_q.acc[0] ^ cmd_q.len);
        mul_b = cmd_q.wide ? sflbh_pkg::WIDE_K : sflbh_pkg::FMX_A;
      end
      STEP_MIX_A: begin
        mul_a = sflbh_pkg::fold33(u_q);
        mul_b = cmd_q.wide ? sflbh_pkg::FMX_A : sflbh_pkg::FMX_B;
      end
      STEP_MIX_B: begin
        mul_a = sflbh_pkg::fold33(u_q);
        mul_b = cmd_q.wide ? sflbh_pkg::FMX_B : sflbh_pkg::FMX_A;
      end
      STEP_MIX_C: begin
        mul_a = sflbh_pkg::fold33(w_q);
        mul_b = sflbh_pkg::FMX_A;
      end
      STEP_MIX_D: begin
        mul_a = sflbh_pkg::fold33(w_q);
        mul_b = sflbh_pkg::FMX_B;
      end
      default: begin
        mul_a = cmd_q.len;
        mul_b = sflbh_pkg::GOLD;
      end
    endcase
  end

  assign last_step = cmd_q.wide ? (step_q == STEP_MIX_D) : (step_q == STEP_MIX_B);

  sflbh_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= STEP_PRE_A;
      cmd_q   <= '0;
      u_q     <= '0;
      w_q     <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (start_i) begin
            cmd_q   <= cmd_i;
            step_q  <= STEP_PRE_A;
            state_q <= F_ISSUE;
          end
        end
        F_ISSUE: state_q <= F_PP;
        F_PP:    state_q <= F_SUM;
        F_SUM: begin
          case (step_q)
            STEP_PRE_A: begin
              if (cmd_q.wide) begin
                u_q <= cmd_q.acc[1] ^ prod ^ cmd_q.acc[3] ^ cmd_q.len;
              end else begin
                u_q <= cmd_q.acc[1] ^ prod;
              end
            end
            STEP_PRE_B: begin
              if (cmd_q.wide) begin
                w_q <= cmd_q.acc[0] ^ cmd_q.len ^ cmd_q.acc[2] ^ prod;
              end else begin
                w_q <= sflbh_pkg::fold33(prod);
              end
            end
            STEP_MIX_A: begin
              // wide chain: keep the raw product, the next step folds it
              if (cmd_q.wide) begin
                u_q <= prod;
              end else begin
                u_q <= sflbh_pkg::fold33(prod) ^ w_q ^ cmd_q.acc[2] ^ cmd_q.acc[3];
              end
            end
            STEP_MIX_B: begin
              u_q <= sflbh_pkg::fold33(prod);
              if (!cmd_q.wide) begin
                w_q <= '0;
              end
            end
            STEP_MIX_C: w_q <= prod;
            STEP_MIX_D: w_q <= sflbh_pkg::fold33(prod);
            default: u_q <= u_q;
          endcase
          if (last_step) begin
            state_q <= F_DONE;
          end else begin
            step_q  <= fin_step_e'(3'(step_q + 3'd1));
            state_q <= F_ISSUE;
          end
        end
        F_DONE: begin
          if (ack_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign done_o      = (state_q == F_DONE);
  assign hash_low_o  = u_q;
  assign hash_high_o = w_q;

  `SFLBH_ASSERT_NOW(a_narrow_steps, clk_i, rst_ni, (state_q == F_SUM && !cmd_q.wide), (step_q == STEP_PRE_A || step_q == STEP_PRE_B || step_q == STEP_MIX_A || step_q == STEP_MIX_B), "narrow finalisation ran past its last step")

endmodule
`default_nettype wire

>>> sv/seeded_four_lane_block_hash.sv
// Top level: seeded four-lane block hash with lane array, merge stage and finaliser
`timescale 1ns / 1ps
`default_nettype none
`include "seeded_four_lane_block_hash_assert.svh"
// A full block runs two chained two-stage multiplies in each lane, a short last block
// one masked tail multiply, an empty last block none; a last block then adds a
// finalisation whose steps share one multiplier, with more steps in 128-bit mode.
// Only one block is in flight: a new block is taken once the last one, and any
// finalisation that it started, is done.
// Reset: asynchronous, clears control and output registers (not accumulators or length); seed and mode read as zero.
module seeded_four_lane_block_hash (
  input  logic  clk_i,
  input  logic  rst_ni,
  sflbh_cfg_if.sink   cfg_i,
  sflbh_in_if.sink    in_i,
  sflbh_out_if.source out_o
);

  typedef enum logic [1:0] {TS_IDLE, TS_LANES, TS_FSTART, TS_FINAL} top_state_e;

  localparam int unsigned NL = sflbh_pkg::NLANES;

  top_state_e                   state_q;
  logic                         in_msg_q;
  logic                         mode_wide_q;
  logic                         last_q;
  logic                         full_q;
  sflbh_pkg::word_t             seed_q;
  logic                         wide_cfg_q;
  logic                         out_valid_q;
  sflbh_pkg::word_t             out_low_q;
  sflbh_pkg::word_t             out_high_q;
  sflbh_pkg::word_t             acc_q [NL];
  sflbh_pkg::word_t             len_q;

  logic                         in_acc;
  logic [sflbh_pkg::LEN_W-1:0]  len_clamp;
  logic [sflbh_pkg::LEN_W-1:0]  add_len;
  logic                         blk_full;
  sflbh_pkg::word_t             seed_eff;
  sflbh_pkg::word_t             lane_word [NL];
  sflbh_pkg::lane_cmd_t         lane_cmd [NL];
  sflbh_pkg::word_t             lane_res [NL];
  logic [NL-1:0]                lane_done;
  logic                         merge_now;
  sflbh_pkg::word_t             merged [NL];
  sflbh_pkg::fin_cmd_t          fin_cmd;
  logic                         fin_done;
  logic                         fin_load;
  sflbh_pkg::word_t             fin_low;
  sflbh_pkg::word_t             fin_high;

  // Input side: one block in flight at a time
  assign in_i.ready = (state_q == TS_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Byte count of this beat: clamp oversize counts; non-last beats are whole blocks
  assign len_clamp = (in_i.valid_bytes > sflbh_pkg::LEN_W'(sflbh_pkg::BLOCK_BYTES)) ?
                     sflbh_pkg::LEN_W'(sflbh_pkg::BLOCK_BYTES) : in_i.valid_bytes;
  assign blk_full  = !in_i.last_block ||
                     (len_clamp == sflbh_pkg::LEN_W'(sflbh_pkg::BLOCK_BYTES));
  assign add_len   = in_i.last_block ? len_clamp :
                     sflbh_pkg::LEN_W'(sflbh_pkg::BLOCK_BYTES);

  // Seed only enters the 64-bit mode
  assign seed_eff = wide_cfg_q ? '0 : seed_q;

  always_comb begin
    lane_word[0] = in_i.lane_zero;
    lane_word[1] = in_i.lane_one;
    lane_word[2] = in_i.lane_two;
    lane_word[3] = in_i.lane_three;
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    logic [sflbh_pkg::LEN_W-1:0] rem;
    logic                        present;

    // bytes of this group still inside the count
    assign rem     = len_clamp - sflbh_pkg::LEN_W'(sflbh_pkg::LANE_BYTES * g);
    assign present = len_clamp > sflbh_pkg::LEN_W'(sflbh_pkg::LANE_BYTES * g);

    // first beat of a message starts from the initial constants
    assign lane_cmd[g].acc    = in_msg_q ? acc_q[g] : (sflbh_pkg::INIT_CONST[g] ^ seed_eff);
    assign lane_cmd[g].word   = lane_word[g];
    assign lane_cmd[g].nbytes = (rem > sflbh_pkg::LEN_W'(sflbh_pkg::LANE_BYTES)) ?
                                4'(sflbh_pkg::LANE_BYTES) : rem[3:0];
    assign lane_cmd[g].op     = blk_full ? sflbh_pkg::LOP_FULL :
                                (present ? sflbh_pkg::LOP_TAIL : sflbh_pkg::LOP_SKIP);

    sflbh_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (in_acc),
      .cmd_i    (lane_cmd[g]),
      .lane_k_i (sflbh_pkg::lane_const(2'(g))),
      .done_o   (lane_done[g]),
      .res_o    (lane_res[g])
    );
  end

  // Merge stage: cross-mix after a full round, plain write-back after a tail step
  always_comb begin
    if (full_q) begin
      merged[0] = lane_res[0] ^ lane_res[2];
      merged[1] = lane_res[1] ^ lane_res[3];
      merged[2] = lane_res[2] ^ merged[0];
      merged[3] = lane_res[3] ^ merged[1];
    end else begin
      merged[0] = lane_res[0];
      merged[1] = lane_res[1];
      merged[2] = lane_res[2];
      merged[3] = lane_res[3];
    end
  end

  assign merge_now = (state_q == TS_LANES) && (&lane_done);

  // Snapshot for the finaliser
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      fin_cmd.acc[i] = acc_q[i];
    end
    fin_cmd.len  = len_q;
    fin_cmd.wide = mode_wide_q;
  end

  sflbh_final u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (state_q == TS_FSTART),
    .cmd_i       (fin_cmd),
    .ack_i       (fin_load),
    .done_o      (fin_done),
    .hash_low_o  (fin_low),
    .hash_high_o (fin_high)
  );

  // Move the result into the output register once it is free or being drained
  assign fin_load = (state_q == TS_FINAL) && fin_done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_IDLE;
      in_msg_q    <= 1'b0;
      mode_wide_q <= 1'b0;
      last_q      <= 1'b0;
      full_q      <= 1'b0;
      seed_q      <= '0;
      wide_cfg_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_low_q   <= '0;
      out_high_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          sflbh_pkg::CFG_SEED: seed_q     <= cfg_i.data;
          sflbh_pkg::CFG_WIDE: wide_cfg_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      // drop the result once its beat is taken, unless a new one replaces it
      if (out_o.ready && !fin_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        TS_IDLE: begin
          if (in_acc) begin
            in_msg_q <= 1'b1;
            if (!in_msg_q) begin
              mode_wide_q <= wide_cfg_q;
            end
            last_q  <= in_i.last_block;
            full_q  <= blk_full;
            state_q <= TS_LANES;
          end
        end
        TS_LANES: begin
          if (&lane_done) begin
            state_q <= last_q ? TS_FSTART : TS_IDLE;
          end
        end
        TS_FSTART: state_q <= TS_FINAL;
        TS_FINAL: begin
          if (fin_load) begin
            out_valid_q <= 1'b1;
            out_low_q   <= fin_low;
            out_high_q  <= fin_high;
            in_msg_q    <= 1'b0;
            state_q     <= TS_IDLE;
          end
        end
        default: state_q <= TS_IDLE;
      endcase
    end
  end

  // Accumulators and running length; only read once a message has started
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      len_q <= (in_msg_q ? len_q : '0) + sflbh_pkg::WORD_W'(add_len);
    end
    if (merge_now) begin
      for (int i = 0; i < NL; i++) begin
        acc_q[i] <= merged[i];
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hash_low  = out_low_q;
  assign out_o.hash_high = out_high_q;

  `SFLBH_ASSERT_NOW(a_lanes_lockstep, clk_i, rst_ni, (state_q == TS_LANES && full_q), (lane_done == '0 || (&lane_done)), "lanes of a full round finished apart")
  `SFLBH_ASSERT_NOW(a_out_from_final, clk_i, rst_ni, $rose(out_valid_q), $past(fin_done), "result loaded without a finished finalisation")
  `SFLBH_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, (!in_i.ready && state_q == TS_LANES), "block not busy after taking a beat")

endmodule
`default_nettype wire
